FILE: src/edrc_pkg.sv
// Shared types and constants for the event drift and rotation correction block.
package edrc_pkg;

   localparam int CNT_W = 5;
   localparam int OP_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [0:0] CMD_LOAD = 1'b0;
   localparam logic [0:0] CMD_EVENT = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_OUT = 2'd1;
   localparam logic [1:0] ST_DROP = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 2'd3;

   localparam logic [OP_W-1:0] OP_NONE = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
   localparam logic [OP_W-1:0] OP_EVENT = 4'd2;
   localparam logic [OP_W-1:0] OP_SCAN = 4'd3;
   localparam logic [OP_W-1:0] OP_DIV_INIT = 4'd4;
   localparam logic [OP_W-1:0] OP_DIV = 4'd5;
   localparam logic [OP_W-1:0] OP_LERP = 4'd6;
   localparam logic [OP_W-1:0] OP_CORDIC_INIT = 4'd7;
   localparam logic [OP_W-1:0] OP_CORDIC = 4'd8;
   localparam logic [OP_W-1:0] OP_ROT = 4'd9;
   localparam logic [OP_W-1:0] OP_FINISH = 4'd10;

   localparam logic signed [33:0] DEG90 = 34'sd1509949440;
   localparam logic signed [33:0] DEG180 = 34'sd3019898880;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic signed [33:0] ATAN_DEG [32] = '{
      34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
      34'sd60000934, 34'sd30029717, 34'sd15018523, 34'sd7509720,
      34'sd3754917, 34'sd1877466, 34'sd938734, 34'sd469367,
      34'sd234684, 34'sd117342, 34'sd58670, 34'sd29335,
      34'sd14668, 34'sd7334, 34'sd3667, 34'sd1833,
      34'sd917, 34'sd458, 34'sd229, 34'sd115,
      34'sd57, 34'sd29, 34'sd14, 34'sd7,
      34'sd4, 34'sd2, 34'sd1, 34'sd0
   };

   typedef struct packed {
      logic [0:0] command;
      logic [9:0] entry_index;
      logic [47:0] sample_time;
      logic signed [31:0] aspect_dx;
      logic signed [31:0] aspect_dy;
      logic signed [31:0] aspect_angle;
      logic [28:0] event_x;
      logic [28:0] event_y;
   } req_type;

   typedef struct packed {
      logic [28:0] corrected_x;
      logic [28:0] corrected_y;
      logic [1:0] event_status;
   } rsp_type;

   typedef struct packed {
      logic [47:0] stamp;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] angle;
   } entry_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [CNT_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic few_records;
      logic scan_hit;
      logic scan_last;
   } stat_type;

endpackage

FILE: src/edrc_ctrl.sv
// Sequencer for table search, division, interpolation, CORDIC and rotation.
module edrc_ctrl #(
   parameter int CORDIC_STEPS = 24
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic req_command,
   input edrc_pkg::stat_type stat,
   output logic busy,
   output edrc_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SCAN = 4'd1;
   localparam logic [3:0] S_DIVI = 4'd2;
   localparam logic [3:0] S_DIV = 4'd3;
   localparam logic [3:0] S_LERP = 4'd4;
   localparam logic [3:0] S_CINIT = 4'd5;
   localparam logic [3:0] S_CORD = 4'd6;
   localparam logic [3:0] S_ROT = 4'd7;
   localparam logic [3:0] S_FIN = 4'd8;

   localparam logic [edrc_pkg::CNT_W-1:0] LAST_CORD = edrc_pkg::CNT_W'(CORDIC_STEPS - 1);
   localparam logic [edrc_pkg::CNT_W-1:0] LAST_DIV = edrc_pkg::CNT_W'(30);
   localparam logic [edrc_pkg::CNT_W-1:0] LAST_LERP = edrc_pkg::CNT_W'(3);
   localparam logic [edrc_pkg::CNT_W-1:0] LAST_ROT = edrc_pkg::CNT_W'(4);

   logic [3:0] state_ff, state_in;
   logic [edrc_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd.op = edrc_pkg::OP_NONE;
      cmd.step = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_command == edrc_pkg::CMD_LOAD) begin
                  cmd.op = edrc_pkg::OP_LOAD;
               end else begin
                  cmd.op = edrc_pkg::OP_EVENT;
                  state_in = stat.few_records ? S_CINIT : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.op = edrc_pkg::OP_SCAN;
            if (stat.scan_hit) begin
               state_in = S_DIVI;
            end else if (stat.scan_last) begin
               state_in = S_CINIT;
            end
         end
         S_DIVI: begin
            cmd.op = edrc_pkg::OP_DIV_INIT;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = edrc_pkg::OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_DIV) begin
               cnt_in = '0;
               state_in = S_LERP;
            end
         end
         S_LERP: begin
            cmd.op = edrc_pkg::OP_LERP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_LERP) begin
               state_in = S_CINIT;
            end
         end
         S_CINIT: begin
            cmd.op = edrc_pkg::OP_CORDIC_INIT;
            cnt_in = '0;
            state_in = S_CORD;
         end
         S_CORD: begin
            cmd.op = edrc_pkg::OP_CORDIC;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CORD) begin
               cnt_in = '0;
               state_in = S_ROT;
            end
         end
         S_ROT: begin
            cmd.op = edrc_pkg::OP_ROT;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ROT) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.op = edrc_pkg::OP_FINISH;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVI) |=> (state_ff == S_DIV && cnt_ff == '0))
      else $error("divide did not start at step zero");
   a_lerp_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LERP && cnt_ff == '0) |-> ($past(state_ff) == S_DIV))
      else $error("interpolation entered without divide");
   a_rot_to_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> ($past(state_ff) == S_ROT && $past(cnt_ff) == LAST_ROT))
      else $error("finish without full rotation");

endmodule

FILE: src/edrc_dp.sv
// Datapath: aspect table, interval search, divider, interpolation, CORDIC, rotation.
module edrc_dp #(
   parameter int TABLE_DEPTH = 1024
) (
   input logic clock,
   input logic reset,
   input edrc_pkg::req_type req_item,
   input edrc_pkg::cmd_type cmd,
   input logic csr_wr_en,
   input logic [edrc_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [edrc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output edrc_pkg::stat_type stat,
   output logic rsp_valid,
   output edrc_pkg::rsp_type rsp_item
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   edrc_pkg::entry_type mem [TABLE_DEPTH];
   edrc_pkg::entry_type cur_ff, prev_ff;

   logic [10:0] count_ff;
   logic [12:0] width_ff, height_ff;
   logic [3:0] scale_ff;

   logic [CW-1:0] idx_ff, n_w;
   logic [47:0] t_ff;
   logic [28:0] ex_ff, ey_ff;
   logic found_ff;
   logic [48:0] rem_ff, rem_sh;
   logic [47:0] den_ff;
   logic [30:0] frac_ff;
   logic signed [34:0] mul_a, mul_b;
   logic signed [69:0] prod_ff, acc_ff, sumx_ff, sumy_ff;
   logic signed [33:0] ang_ff, cz_ff, cxr_ff, cyr_ff, c_v, s_v, lerp_base, lerp_v;
   logic signed [39:0] dx_ff, dy_ff, xr, yr;
   logic neg_ff;
   logic [27:0] cx, cy;
   logic signed [30:0] i1, j1;
   logic hit, last, scan_adv, wr_ok, inb;
   logic rsp_valid_ff;
   edrc_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         width_ff <= 13'd4800;
         height_ff <= 13'd4800;
         scale_ff <= 4'd8;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            edrc_pkg::CSR_COUNT: count_ff <= 11'(csr_wdata);
            edrc_pkg::CSR_WIDTH: width_ff <= csr_wdata;
            edrc_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
            edrc_pkg::CSR_SCALE: scale_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   assign n_w = (32'(count_ff) < 32'(TABLE_DEPTH)) ? CW'(count_ff) : CW'(TABLE_DEPTH);
   assign wr_ok = 32'(req_item.entry_index) < 32'(TABLE_DEPTH);
   assign hit = (idx_ff >= CW'(2)) && (t_ff >= prev_ff.stamp) && (t_ff < cur_ff.stamp);
   assign last = idx_ff >= n_w;
   assign scan_adv = (cmd.op == edrc_pkg::OP_SCAN) && !hit && !last;

   assign stat.few_records = n_w < CW'(2);
   assign stat.scan_hit = hit;
   assign stat.scan_last = last;

   always_ff @(posedge clock) begin
      if (cmd.op == edrc_pkg::OP_LOAD && wr_ok) begin
         mem[AW'(req_item.entry_index)] <= '{stamp: req_item.sample_time,
            dx: req_item.aspect_dx, dy: req_item.aspect_dy, angle: req_item.aspect_angle};
      end
      if (scan_adv) begin
         cur_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   assign cx = {width_ff[12:1], 16'd0};
   assign cy = {height_ff[12:1], 16'd0};
   assign i1 = $signed({2'b0, ex_ff}) - $signed({3'b0, cx});
   assign j1 = $signed({2'b0, ey_ff}) - $signed({3'b0, cy});
   assign c_v = neg_ff ? -cxr_ff : cxr_ff;
   assign s_v = neg_ff ? -cyr_ff : cyr_ff;
   assign rem_sh = {rem_ff[47:0], 1'b0};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.op == edrc_pkg::OP_LERP) begin
         mul_b = $signed({4'b0, frac_ff});
         unique case (cmd.step)
            5'd0: mul_a = 35'($signed({cur_ff.angle[31], cur_ff.angle})
                  - $signed({prev_ff.angle[31], prev_ff.angle}));
            5'd1: mul_a = 35'($signed({cur_ff.dx[31], cur_ff.dx})
                  - $signed({prev_ff.dx[31], prev_ff.dx}));
            5'd2: mul_a = 35'($signed({cur_ff.dy[31], cur_ff.dy})
                  - $signed({prev_ff.dy[31], prev_ff.dy}));
            default: mul_a = '0;
         endcase
      end else if (cmd.op == edrc_pkg::OP_ROT) begin
         unique case (cmd.step)
            5'd0: begin mul_a = 35'(i1); mul_b = 35'(c_v); end
            5'd1: begin mul_a = 35'(j1); mul_b = 35'(s_v); end
            5'd2: begin mul_a = 35'(i1); mul_b = 35'(s_v); end
            5'd3: begin mul_a = 35'(j1); mul_b = 35'(c_v); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   always_comb begin
      unique case (cmd.step)
         5'd1: lerp_base = 34'(prev_ff.angle);
         5'd2: lerp_base = 34'(prev_ff.dx);
         default: lerp_base = 34'(prev_ff.dy);
      endcase
      lerp_v = lerp_base + 34'(prod_ff >>> 31);
   end

   always_comb begin
      xr = 40'(sumx_ff >>> 30) + $signed({12'b0, cx}) - dx_ff;
      yr = 40'(sumy_ff >>> 30) + $signed({12'b0, cy}) - dy_ff;
      inb = (xr > -40'sd65536) && (xr < $signed({11'b0, width_ff, 16'b0}))
         && (yr > -40'sd65536) && (yr < $signed({11'b0, height_ff, 16'b0}));
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (scan_adv) begin
         prev_ff <= cur_ff;
      end
      unique case (cmd.op)
         edrc_pkg::OP_EVENT: begin
            t_ff <= req_item.sample_time;
            ex_ff <= req_item.event_x;
            ey_ff <= req_item.event_y;
            ang_ff <= '0;
            dx_ff <= '0;
            dy_ff <= '0;
         end
         edrc_pkg::OP_DIV_INIT: begin
            rem_ff <= {1'b0, t_ff - prev_ff.stamp};
            den_ff <= cur_ff.stamp - prev_ff.stamp;
            frac_ff <= '0;
         end
         edrc_pkg::OP_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_ff <= rem_sh - {1'b0, den_ff};
               frac_ff <= {frac_ff[29:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               frac_ff <= {frac_ff[29:0], 1'b0};
            end
         end
         edrc_pkg::OP_LERP: begin
            unique case (cmd.step)
               5'd1: ang_ff <= lerp_v;
               5'd2: dx_ff <= 40'(lerp_v) * $signed({36'b0, scale_ff});
               5'd3: dy_ff <= 40'(lerp_v) * $signed({36'b0, scale_ff});
               default: ;
            endcase
         end
         edrc_pkg::OP_CORDIC_INIT: begin
            cxr_ff <= edrc_pkg::CORDIC_GAIN;
            cyr_ff <= '0;
            if (ang_ff > edrc_pkg::DEG90) begin
               cz_ff <= ang_ff - edrc_pkg::DEG180;
               neg_ff <= 1'b1;
            end else if (ang_ff < -edrc_pkg::DEG90) begin
               cz_ff <= ang_ff + edrc_pkg::DEG180;
               neg_ff <= 1'b1;
            end else begin
               cz_ff <= ang_ff;
               neg_ff <= 1'b0;
            end
         end
         edrc_pkg::OP_CORDIC: begin
            if (!cz_ff[33]) begin
               cxr_ff <= cxr_ff - (cyr_ff >>> cmd.step);
               cyr_ff <= cyr_ff + (cxr_ff >>> cmd.step);
               cz_ff <= cz_ff - edrc_pkg::ATAN_DEG[cmd.step];
            end else begin
               cxr_ff <= cxr_ff + (cyr_ff >>> cmd.step);
               cyr_ff <= cyr_ff - (cxr_ff >>> cmd.step);
               cz_ff <= cz_ff + edrc_pkg::ATAN_DEG[cmd.step];
            end
         end
         edrc_pkg::OP_ROT: begin
            unique case (cmd.step)
               5'd1: acc_ff <= prod_ff;
               5'd2: sumx_ff <= acc_ff - prod_ff;
               5'd3: acc_ff <= prod_ff;
               5'd4: sumy_ff <= acc_ff + prod_ff;
               default: ;
            endcase
         end
         edrc_pkg::OP_FINISH: begin
            rsp_ff.corrected_x <= (inb && !xr[39]) ? xr[28:0] : '0;
            rsp_ff.corrected_y <= (inb && !yr[39]) ? yr[28:0] : '0;
            rsp_ff.event_status <= !found_ff ? edrc_pkg::ST_DROP
               : (inb ? edrc_pkg::ST_OK : edrc_pkg::ST_OUT);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.op == edrc_pkg::OP_FINISH);
         if (cmd.op == edrc_pkg::OP_EVENT) begin
            idx_ff <= '0;
            found_ff <= 1'b0;
         end else if (scan_adv) begin
            idx_ff <= idx_ff + 1'b1;
         end else if (cmd.op == edrc_pkg::OP_SCAN && hit) begin
            found_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

endmodule

FILE: src/event_drift_rotate_correct.sv
// Top level of the event drift and rotation correction block.
// A load transfer writes one table entry in the accept cycle; busy stays low.
// An event's run time is set by the one-entry-per-cycle table search,
// the 31-step divider and the CORDIC loop.
// One event is in work at a time; the result strobe lasts one cycle.
// Synchronous reset clears control, resets CSRs; the table is undefined until loaded.
module event_drift_rotate_correct #(
   parameter int TABLE_DEPTH = 1024,
   parameter int CORDIC_STEPS = 24
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input edrc_pkg::req_type req_item,
   output logic rsp_valid,
   output edrc_pkg::rsp_type rsp_item,
   input logic csr_wr_en,
   input logic [edrc_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [edrc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   edrc_pkg::cmd_type cmd;
   edrc_pkg::stat_type stat;

   edrc_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_command(req_item.command),
      .stat(stat),
      .busy(busy),
      .cmd(cmd)
   );

   edrc_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock(clock),
      .reset(reset),
      .req_item(req_item),
      .cmd(cmd),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .stat(stat),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an event in work");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.command == edrc_pkg::CMD_LOAD) |=> !busy && !rsp_valid)
      else $error("load transfer started work");

endmodule
